### hdl/vcs_pkg.sv
package vcs_pkg;

    localparam int CHUNK_SIZE_DEF   = 16;
    localparam int CHUNK_HEIGHT_DEF = 256;
    localparam int DATA_WIDTH_DEF   = 32;

    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_XW       = 24;
    localparam int IN_YW       = 16;
    localparam int IN_ZW       = 24;
    localparam int WORD_W      = 32;
    localparam int DATA_OUT_W  = 32;
    localparam int DIR_W       = 3;
    localparam int FACE_COUNT  = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_REMOVE    = 2'd1,
        OP_FIND      = 2'd2,
        OP_NEIGHBORS = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             loc_ok;
        logic [DIR_W-1:0] dir;
        logic             last;
    } t_cmd_ctl;

    localparam logic signed [1:0] FACE_DX [FACE_COUNT] =
        '{2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0};
    localparam logic signed [1:0] FACE_DY [FACE_COUNT] =
        '{2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0, 2'sd0};
    localparam logic signed [1:0] FACE_DZ [FACE_COUNT] =
        '{2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, -2'sd1};

    // width of chunk coordinate times chunk size
    function automatic int base_w(input int cs);
        return CFG_W + $clog2(cs) + 1;
    endfunction

    // width of a local coordinate before range check
    function automatic int loc_w(input int cs);
        return ((base_w(cs) > IN_XW) ? base_w(cs) : IN_XW) + 2;
    endfunction

endpackage

### hdl/vcs_fifo.sv
module vcs_fifo
    import vcs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### hdl/vcs_front.sv
module vcs_front
    import vcs_pkg::*;
#(
    parameter int CHUNK_SIZE   = CHUNK_SIZE_DEF,
    parameter int CHUNK_HEIGHT = CHUNK_HEIGHT_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int IW           = $clog2(CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT),
    parameter int BW           = base_w(CHUNK_SIZE)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [BW-1:0]    i_base_x,
    input  logic signed [BW-1:0]    i_base_z,
    input  logic                    i_clearing,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_opcode,
    input  logic signed [IN_XW-1:0] i_world_x,
    input  logic signed [IN_YW-1:0] i_world_y,
    input  logic signed [IN_ZW-1:0] i_world_z,
    input  logic [WORD_W-1:0]       i_block_word,
    output logic                    o_cmd_valid,
    input  logic                    i_cmd_ready,
    output t_cmd_ctl                o_ctl,
    output logic [IW-1:0]           o_idx,
    output logic [DATA_WIDTH-1:0]   o_word
);

    localparam int LW  = loc_w(CHUNK_SIZE);
    localparam int YSW = IN_YW + 1;
    localparam int XW  = $clog2(CHUNK_SIZE);
    localparam int YW  = $clog2(CHUNK_HEIGHT);

    localparam logic signed [LW-1:0]  CS_L  = LW'(CHUNK_SIZE);
    localparam logic signed [YSW-1:0] CH_Y  = YSW'(CHUNK_HEIGHT);
    localparam logic [IW-1:0]         CS_I  = IW'(CHUNK_SIZE);
    localparam logic [IW-1:0]         CS2_I = IW'(CHUNK_SIZE * CHUNK_SIZE);

    logic                     r_busy;
    t_op                      r_op;
    logic signed [LW-1:0]     r_lx;
    logic signed [LW-1:0]     r_lz;
    logic signed [YSW-1:0]    r_y;
    logic [WORD_W-1:0]        r_word;
    logic [DIR_W-1:0]         r_face;

    logic                     nb;
    logic signed [1:0]        dx;
    logic signed [1:0]        dy;
    logic signed [1:0]        dz;
    logic signed [LW-1:0]     lx_f;
    logic signed [LW-1:0]     lz_f;
    logic signed [YSW-1:0]    y_f;
    logic                     loc_ok;
    logic                     push;
    logic                     accept;
    logic [DATA_WIDTH+WORD_W-1:0] word_ext;

    always_comb begin
        nb   = (r_op == OP_NEIGHBORS);
        dx   = nb ? FACE_DX[r_face] : 2'sd0;
        dy   = nb ? FACE_DY[r_face] : 2'sd0;
        dz   = nb ? FACE_DZ[r_face] : 2'sd0;
        lx_f = r_lx + LW'(dx);
        lz_f = r_lz + LW'(dz);
        y_f  = r_y + YSW'(dy);
        loc_ok = !lx_f[LW-1] && (lx_f < CS_L)
              && !lz_f[LW-1] && (lz_f < CS_L)
              && !y_f[YSW-1] && (y_f < CH_Y);
        o_idx = '0;
        if (loc_ok) begin
            o_idx = IW'(lx_f[XW-1:0]) + IW'(lz_f[XW-1:0]) * CS_I
                  + IW'(y_f[YW-1:0]) * CS2_I;
        end
        o_ctl.op     = r_op;
        o_ctl.loc_ok = loc_ok;
        o_ctl.dir    = nb ? r_face : '0;
        o_ctl.last   = !nb || (r_face == DIR_W'(FACE_COUNT - 1));
    end

    assign word_ext    = {{DATA_WIDTH{1'b0}}, r_word};
    assign o_word      = word_ext[DATA_WIDTH-1:0];
    assign o_cmd_valid = r_busy;
    assign push        = r_busy && i_cmd_ready;
    assign o_ready     = (!r_busy || (push && o_ctl.last)) && !i_clearing;
    assign accept      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_opcode);
            r_lx   <= LW'(i_world_x) - LW'(i_base_x);
            r_lz   <= LW'(i_world_z) - LW'(i_base_z);
            r_y    <= YSW'(i_world_y);
            r_word <= i_block_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_face <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_face <= '0;
            end else if (push) begin
                if (o_ctl.last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_face <= r_face + DIR_W'(1);
                end
            end
        end
    end

endmodule

### hdl/vcs_back.sv
module vcs_back
    import vcs_pkg::*;
#(
    parameter int CHUNK_SIZE   = CHUNK_SIZE_DEF,
    parameter int CHUNK_HEIGHT = CHUNK_HEIGHT_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
    parameter int IW           = $clog2(CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  t_cmd_ctl              i_ctl,
    input  logic [IW-1:0]         i_idx,
    input  logic [DATA_WIDTH-1:0] i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ok,
    output logic [DATA_OUT_W-1:0] o_data_out,
    output logic [DIR_W-1:0]      o_direction,
    output logic                  o_last,
    output logic                  o_clearing
);

    localparam int CELLS = CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT;

    logic                  r_occ_mem  [CELLS];
    logic [DATA_WIDTH-1:0] r_data_mem [CELLS];

    logic                  r_clr_busy;
    logic [IW-1:0]         r_clr_idx;

    logic                  r_occ_rd;
    logic [DATA_WIDTH-1:0] r_data_rd;

    logic                  r_e_valid;
    t_cmd_ctl              r_e_ctl;
    logic [IW-1:0]         r_e_idx;
    logic [DATA_WIDTH-1:0] r_e_word;

    logic                  r_byp_hit;
    logic                  r_byp_occ;
    logic [DATA_WIDTH-1:0] r_byp_data;

    logic                  r_o_valid;
    logic                  r_o_ok;
    logic [DATA_OUT_W-1:0] r_o_data;
    logic [DIR_W-1:0]      r_o_dir;
    logic                  r_o_last;

    logic                  e_fire;
    logic                  pop;
    logic                  e_occ;
    logic [DATA_WIDTH-1:0] e_dat;
    logic                  e_ok;
    logic                  e_show;
    logic                  e_wr_occ;
    logic                  e_occ_new;
    logic                  e_wr_dat;
    logic [DATA_OUT_W+DATA_WIDTH-1:0] dat_ext;

    assign e_fire      = r_e_valid && (!r_o_valid || i_ready);
    assign o_cmd_ready = (!r_e_valid || e_fire) && !r_clr_busy;
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign o_clearing  = r_clr_busy;

    always_comb begin
        e_occ     = r_byp_hit ? r_byp_occ  : r_occ_rd;
        e_dat     = r_byp_hit ? r_byp_data : r_data_rd;
        e_ok      = 1'b0;
        e_show    = 1'b0;
        e_wr_occ  = 1'b0;
        e_occ_new = 1'b0;
        e_wr_dat  = 1'b0;
        unique case (r_e_ctl.op)
            OP_ADD: begin
                e_ok      = r_e_ctl.loc_ok;
                e_wr_occ  = e_fire && e_ok;
                e_occ_new = 1'b1;
                e_wr_dat  = e_fire && e_ok;
            end
            OP_REMOVE: begin
                e_ok      = r_e_ctl.loc_ok && e_occ;
                e_wr_occ  = e_fire && e_ok;
            end
            OP_FIND, OP_NEIGHBORS: begin
                e_ok   = r_e_ctl.loc_ok && e_occ;
                e_show = e_ok;
            end
        endcase
        dat_ext = {{DATA_OUT_W{1'b0}}, (e_show ? e_dat : {DATA_WIDTH{1'b0}})};
    end

    // occupancy: clearing sweep after reset, then read-modify-write
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_occ_mem[r_clr_idx] <= 1'b0;
        end else if (e_wr_occ) begin
            r_occ_mem[r_e_idx] <= e_occ_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_wr_dat) begin
            r_data_mem[r_e_idx] <= r_e_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_occ_rd  <= r_occ_mem[i_idx];
            r_data_rd <= r_data_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_e_ctl    <= i_ctl;
            r_e_idx    <= i_idx;
            r_e_word   <= i_word;
            r_byp_hit  <= e_wr_occ && (r_e_idx == i_idx);
            r_byp_occ  <= e_occ_new;
            r_byp_data <= r_e_word;
        end
        if (e_fire) begin
            r_o_ok   <= e_ok;
            r_o_data <= dat_ext[DATA_OUT_W-1:0];
            r_o_dir  <= r_e_ctl.dir;
            r_o_last <= r_e_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_e_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + IW'(1);
                if (r_clr_idx == IW'(CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (pop) begin
                r_e_valid <= 1'b1;
            end else if (e_fire) begin
                r_e_valid <= 1'b0;
            end
            if (e_fire) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_ok        = r_o_ok;
    assign o_data_out  = r_o_data;
    assign o_direction = r_o_dir;
    assign o_last      = r_o_last;

endmodule

### hdl/voxel_chunk_store_core.sv
// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_opcode, i_world_x/y/z, i_block_word
// result    out        o_valid / i_ready   o_ok, o_data_out, o_direction, o_last
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// Add, remove and find issue one probe each; a neighbour query issues six, one
// face probe per cycle while the queue takes them, set by the single read port
// of the cell memory. The back reads one cell a cycle while its results are taken.
// After reset the occupancy memory is swept clear, one cell a cycle, over all
// CHUNK_SIZE*CHUNK_SIZE*CHUNK_HEIGHT cells (65536 by default); no request is taken.
// A stalled result holds the back; a full probe queue holds the front.
module voxel_chunk_store_core
    import vcs_pkg::*;
#(
    parameter int CHUNK_SIZE   = CHUNK_SIZE_DEF,
    parameter int CHUNK_HEIGHT = CHUNK_HEIGHT_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_opcode,
    input  logic signed [IN_XW-1:0] i_world_x,
    input  logic signed [IN_YW-1:0] i_world_y,
    input  logic signed [IN_ZW-1:0] i_world_z,
    input  logic [WORD_W-1:0]       i_block_word,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_ok,
    output logic [DATA_OUT_W-1:0]   o_data_out,
    output logic [DIR_W-1:0]        o_direction,
    output logic                    o_last
);

    localparam int IW = $clog2(CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT);
    localparam int BW = base_w(CHUNK_SIZE);
    localparam int QW = $bits(t_cmd_ctl) + IW + DATA_WIDTH;
    localparam logic signed [BW-1:0] CS_S = BW'(CHUNK_SIZE);

    logic signed [BW-1:0]    r_base_x;
    logic signed [BW-1:0]    r_base_z;
    logic signed [CFG_W-1:0] cfg_s;
    logic signed [BW-1:0]    cfg_base;

    logic                  clearing;
    logic                  f_valid;
    logic                  f_ready;
    t_cmd_ctl              f_ctl;
    logic [IW-1:0]         f_idx;
    logic [DATA_WIDTH-1:0] f_word;
    logic                  q_valid;
    logic                  q_ready;
    logic [QW-1:0]         q_data;
    t_cmd_ctl              q_ctl;
    logic [IW-1:0]         q_idx;
    logic [DATA_WIDTH-1:0] q_word;

    assign cfg_s    = i_cfg_data;
    assign cfg_base = BW'(cfg_s) * CS_S;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CHUNK_X: r_base_x <= cfg_base;
                REG_CHUNK_Z: r_base_z <= cfg_base;
            endcase
        end
    end

    vcs_front #(
        .CHUNK_SIZE   (CHUNK_SIZE),
        .CHUNK_HEIGHT (CHUNK_HEIGHT),
        .DATA_WIDTH   (DATA_WIDTH),
        .IW           (IW),
        .BW           (BW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_base_x     (r_base_x),
        .i_base_z     (r_base_z),
        .i_clearing   (clearing),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .i_block_word (i_block_word),
        .o_cmd_valid  (f_valid),
        .i_cmd_ready  (f_ready),
        .o_ctl        (f_ctl),
        .o_idx        (f_idx),
        .o_word       (f_word)
    );

    vcs_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_ctl, f_idx, f_word}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign {q_ctl, q_idx, q_word} = q_data;

    vcs_back #(
        .CHUNK_SIZE   (CHUNK_SIZE),
        .CHUNK_HEIGHT (CHUNK_HEIGHT),
        .DATA_WIDTH   (DATA_WIDTH),
        .IW           (IW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .o_cmd_ready  (q_ready),
        .i_ctl        (q_ctl),
        .i_idx        (q_idx),
        .i_word       (q_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ok         (o_ok),
        .o_data_out   (o_data_out),
        .o_direction  (o_direction),
        .o_last       (o_last),
        .o_clearing   (clearing)
    );

`ifndef SYNTH
    a_no_req_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_ready)
        else $error("request taken during occupancy sweep");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_valid && !q_valid)
        else $error("work in flight during occupancy sweep");

    a_neighbour_last_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && (o_direction != '0) |-> o_direction == DIR_W'(FACE_COUNT - 1))
        else $error("final neighbour result on wrong face");

    a_queue_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !f_ready |=> f_valid && $stable(f_ctl) && $stable(f_idx))
        else $error("front probe changed while queue full");
`endif

endmodule

### tb/voxel_chunk_store_core_tb.sv
`timescale 1ns / 1ps

module voxel_chunk_store_core_tb;
    import vcs_pkg::*;

    localparam int CHUNK_SIZE     = CHUNK_SIZE_DEF;
    localparam int CHUNK_HEIGHT   = CHUNK_HEIGHT_DEF;
    localparam int CELL_COUNT     = CHUNK_SIZE * CHUNK_SIZE * CHUNK_HEIGHT;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int PHASE_ITEMS    = 34;
    localparam int N_DIRECTED     = 26;

    localparam int FACE_X [FACE_COUNT] = '{1, -1, 0, 0, 0, 0};
    localparam int FACE_Y [FACE_COUNT] = '{0, 0, 1, -1, 0, 0};
    localparam int FACE_Z [FACE_COUNT] = '{0, 0, 0, 0, 1, -1};

    typedef struct packed {
        t_op                     op;
        logic signed [IN_XW-1:0] x;
        logic signed [IN_YW-1:0] y;
        logic signed [IN_ZW-1:0] z;
        logic [WORD_W-1:0]       word;
    } t_voxel_req;

    typedef struct packed {
        logic                  ok;
        logic [DATA_OUT_W-1:0] data;
        logic [DIR_W-1:0]      dir;
        logic                  last;
    } t_voxel_result;

    typedef struct packed {
        t_voxel_req            req;
        logic                  typed;
        logic                  ok;
        logic [DATA_OUT_W-1:0] data;
    } t_directed_row;

    // typed rows carry a single-result expectation; the rest go to the predictor
    localparam t_directed_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{OP_FIND,      0,        0,      0,        32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_ADD,       0,        0,      0,        32'hFFFF_FFFF}, 1'b1, 1'b1, 32'h0},
        '{'{OP_FIND,      0,        0,      0,        32'h0},         1'b1, 1'b1, 32'hFFFF_FFFF},
        '{'{OP_ADD,       15,       255,    15,       32'h0},         1'b1, 1'b1, 32'h0},
        '{'{OP_FIND,      15,       255,    15,       32'h0},         1'b1, 1'b1, 32'h0},
        '{'{OP_ADD,       1,        0,      0,        32'hA5A5_5A5A}, 1'b1, 1'b1, 32'h0},
        '{'{OP_ADD,       0,        1,      0,        32'h0000_0001}, 1'b1, 1'b1, 32'h0},
        '{'{OP_NEIGHBORS, 0,        0,      0,        32'h0},         1'b0, 1'b0, 32'h0},
        '{'{OP_NEIGHBORS, 15,       255,    15,       32'h0},         1'b0, 1'b0, 32'h0},
        '{'{OP_NEIGHBORS, -1,       0,      0,        32'h0},         1'b0, 1'b0, 32'h0},
        '{'{OP_NEIGHBORS, 0,        -1,     0,        32'h0},         1'b0, 1'b0, 32'h0},
        '{'{OP_ADD,       16,       0,      0,        32'h1111_1111}, 1'b1, 1'b0, 32'h0},
        '{'{OP_ADD,       -1,       0,      0,        32'h2222_2222}, 1'b1, 1'b0, 32'h0},
        '{'{OP_FIND,      0,        256,    0,        32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_FIND,      0,        -1,     0,        32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_ADD,       -8388608, -32768, -8388608, 32'hFFFF_FFFF}, 1'b1, 1'b0, 32'h0},
        '{'{OP_FIND,      8388607,  32767,  8388607,  32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_REMOVE,    0,        0,      16,       32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_REMOVE,    5,        5,      5,        32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_REMOVE,    1,        0,      0,        32'h0},         1'b1, 1'b1, 32'h0},
        '{'{OP_REMOVE,    1,        0,      0,        32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_FIND,      1,        0,      0,        32'h0},         1'b1, 1'b0, 32'h0},
        '{'{OP_ADD,       0,        0,      0,        32'h1234_5678}, 1'b1, 1'b1, 32'h0},
        '{'{OP_FIND,      0,        0,      0,        32'h0},         1'b1, 1'b1, 32'h1234_5678},
        '{'{OP_NEIGHBORS, 1,        0,      0,        32'h0},         1'b0, 1'b0, 32'h0},
        '{'{OP_NEIGHBORS, 8388607,  32767,  -8388608, 32'h0},         1'b0, 1'b0, 32'h0}
    };

    logic                    i_clk;
    logic                    i_rst_n      = 1'b0;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx    = REG_CHUNK_X;
    logic [CFG_W-1:0]        i_cfg_data   = '0;
    logic                    i_valid      = 1'b0;
    logic                    o_ready;
    logic [1:0]              i_opcode     = OP_ADD;
    logic signed [IN_XW-1:0] i_world_x    = '0;
    logic signed [IN_YW-1:0] i_world_y    = '0;
    logic signed [IN_ZW-1:0] i_world_z    = '0;
    logic [WORD_W-1:0]       i_block_word = '0;
    logic                    o_valid;
    logic                    i_ready      = 1'b0;
    logic                    o_ok;
    logic [DATA_OUT_W-1:0]   o_data_out;
    logic [DIR_W-1:0]        o_direction;
    logic                    o_last;

    logic signed [CFG_W-1:0] chunk_x_model = '0;
    logic signed [CFG_W-1:0] chunk_z_model = '0;
    bit                      occ_model [CELL_COUNT];
    logic [WORD_W-1:0]       word_model [CELL_COUNT];
    t_voxel_result           pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    voxel_chunk_store_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_world_x    (i_world_x),
        .i_world_y    (i_world_y),
        .i_world_z    (i_world_z),
        .i_block_word (i_block_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ok         (o_ok),
        .o_data_out   (o_data_out),
        .o_direction  (o_direction),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit find_cell(input longint gx, input longint gy, input longint gz,
                                     output longint idx);
        longint lx;
        longint lz;
        lx  = gx - longint'(chunk_x_model) * CHUNK_SIZE;
        lz  = gz - longint'(chunk_z_model) * CHUNK_SIZE;
        idx = 0;
        if (lx < 0 || lx >= CHUNK_SIZE || lz < 0 || lz >= CHUNK_SIZE)
            return 1'b0;
        if (gy < 0 || gy >= CHUNK_HEIGHT)
            return 1'b0;
        idx = lx + lz * CHUNK_SIZE + gy * CHUNK_SIZE * CHUNK_SIZE;
        return idx < CELL_COUNT;
    endfunction

    task automatic add_expected(input t_voxel_result res);
        pending_results = {pending_results, res};
    endtask

    task automatic predict_voxel_results(input t_voxel_req r, input bit keep);
        t_voxel_result res;
        longint        gx;
        longint        gy;
        longint        gz;
        longint        idx;
        int            f;
        gx = $signed(r.x);
        gy = $signed(r.y);
        gz = $signed(r.z);
        if (r.op == OP_NEIGHBORS) begin
            for (f = 0; f < FACE_COUNT; f++) begin
                res      = '0;
                res.dir  = f[DIR_W-1:0];
                res.last = (f == FACE_COUNT - 1);
                if (find_cell(gx + FACE_X[f], gy + FACE_Y[f], gz + FACE_Z[f], idx)
                        && occ_model[idx]) begin
                    res.ok   = 1'b1;
                    res.data = word_model[idx];
                end
                if (keep)
                    add_expected(res);
            end
        end else begin
            res      = '0;
            res.last = 1'b1;
            if (find_cell(gx, gy, gz, idx)) begin
                case (r.op)
                    OP_ADD: begin
                        word_model[idx] = r.word;
                        occ_model[idx]  = 1'b1;
                        res.ok          = 1'b1;
                    end
                    OP_REMOVE: begin
                        if (occ_model[idx]) begin
                            occ_model[idx] = 1'b0;
                            res.ok         = 1'b1;
                        end
                    end
                    default: begin
                        if (occ_model[idx]) begin
                            res.ok   = 1'b1;
                            res.data = word_model[idx];
                        end
                    end
                endcase
            end
            if (keep)
                add_expected(res);
        end
    endtask

    task automatic issue_request(input t_voxel_req r, input bit typed, input logic ok,
                                 input logic [DATA_OUT_W-1:0] data);
        t_voxel_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= r.op;
        i_world_x    <= r.x;
        i_world_y    <= r.y;
        i_world_z    <= r.z;
        i_block_word <= r.word;
        do @(posedge i_clk); while (!o_ready);
        predict_voxel_results(r, !typed);
        if (typed) begin
            res      = '0;
            res.ok   = ok;
            res.data = data;
            res.last = 1'b1;
            add_expected(res);
        end
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_chunk(input logic signed [CFG_W-1:0] cx,
                               input logic signed [CFG_W-1:0] cz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CHUNK_X;
        i_cfg_data <= cx;
        @(posedge i_clk);
        i_cfg_idx  <= REG_CHUNK_Z;
        i_cfg_data <= cz;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        chunk_x_model = cx;
        chunk_z_model = cz;
    endtask

    // mostly a small corner of the chunk so that cells get revisited
    function automatic logic signed [IN_XW-1:0] random_coord(input longint base);
        int     pick;
        longint v;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            v = base + $urandom_range(0, 3);
        else if (pick < 85)
            v = base + $urandom_range(0, CHUNK_SIZE - 1);
        else if (pick < 95)
            v = $urandom_range(0, 1) ? base - 1 : base + CHUNK_SIZE;
        else
            v = longint'($urandom);
        return v[IN_XW-1:0];
    endfunction

    function automatic logic signed [IN_YW-1:0] random_height();
        int     pick;
        longint v;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            v = $urandom_range(0, 3);
        else if (pick < 85)
            v = $urandom_range(0, CHUNK_HEIGHT - 1);
        else if (pick < 95) begin
            case ($urandom_range(0, 3))
                0:       v = -1;
                1:       v = CHUNK_HEIGHT;
                2:       v = CHUNK_HEIGHT - 1;
                default: v = 0;
            endcase
        end else
            v = longint'($urandom);
        return v[IN_YW-1:0];
    endfunction

    function automatic t_voxel_req random_request();
        t_voxel_req r;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.op = OP_ADD;
        else if (pick < 50)
            r.op = OP_REMOVE;
        else if (pick < 75)
            r.op = OP_FIND;
        else
            r.op = OP_NEIGHBORS;
        r.x    = random_coord(longint'(chunk_x_model) * CHUNK_SIZE);
        r.z    = random_coord(longint'(chunk_z_model) * CHUNK_SIZE);
        r.y    = random_height();
        r.word = $urandom;
        return r;
    endfunction

    task automatic run_random_phase(input logic signed [CFG_W-1:0] cx,
                                    input logic signed [CFG_W-1:0] cz,
                                    input int idle_pct, input int stall_pct);
        int k;
        wait_for_results();
        write_chunk(cx, cz);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < PHASE_ITEMS; k++)
            issue_request(random_request(), 1'b0, 1'b0, '0);
    endtask

    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_voxel_result want;
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display(
                    "%0t: unexpected result, expected none, actual ok=%0d data=%h dir=%0d last=%0d",
                    $time, o_ok, o_data_out, o_direction, o_last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("ok", want.ok, o_ok);
                report_field("data_out", want.data, o_data_out);
                report_field("direction", want.dir, o_direction);
                report_field("last", want.last, o_last);
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_chunk(0, 0);
        for (k = 0; k < N_DIRECTED; k++)
            issue_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].typed,
                          DIRECTED_ROWS[k].ok, DIRECTED_ROWS[k].data);
        run_random_phase(20'sh7FFFF, -20'sh80000, 0, 0);
        run_random_phase(-20'sh80000, 20'sh7FFFF, 48, 0);
        run_random_phase(3, -7, 0, 48);
        run_random_phase(0, -1, 19, 19);
        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
hdl/vcs_pkg.sv
hdl/vcs_fifo.sv
hdl/vcs_front.sv
hdl/vcs_back.sv
hdl/voxel_chunk_store_core.sv
tb/voxel_chunk_store_core_tb.sv
